// ----- hw/rtl/cache_lookup_random_replace_macros.svh -----
// Assertion macros for the cache lookup block.
`ifndef CACHE_LOOKUP_RANDOM_REPLACE_MACROS_SVH
`define CACHE_LOOKUP_RANDOM_REPLACE_MACROS_SVH

// Same-cycle implication, checked on every clk edge outside reset.
`define CLRR_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every clk edge outside reset.
`define CLRR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/clrr_pkg.sv -----
// Shared types, constants and functions for the cache lookup block.
package clrr_pkg;

  localparam int DVD_W = 16;  // dividend and quotient width of the shared divider
  localparam int DVR_W = 7;   // divisor and remainder width of the shared divider
  localparam int CNT_W = $clog2(DVD_W + 1);

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_WORDS_PER_BLOCK = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LINES_IN_USE    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SET_COUNT       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_RANDOM_SEED     = 3'd3;

  localparam logic [6:0]  WPB_RESET   = 7'd4;
  localparam logic [4:0]  LINES_RESET = 5'd16;
  localparam logic [4:0]  SETS_RESET  = 5'd4;
  localparam logic [4:0]  SETS_MAX    = 5'd16;
  localparam logic [15:0] SEED_DEFAULT = 16'd44257;
  localparam logic [15:0] LFSR_TAPS    = 16'hB400;

  typedef struct packed {
    logic             start;
    logic [DVD_W-1:0] dividend;
    logic [DVR_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             busy;
    logic [DVD_W-1:0] quotient;
    logic [DVR_W-1:0] remainder;
  } div_rsp_t;

  function automatic logic [15:0] seed_value(input logic [15:0] s);
    return (s == 16'd0) ? SEED_DEFAULT : s;
  endfunction

  // Galois LFSR, shifted right
  function automatic logic [15:0] lfsr_next(input logic [15:0] v);
    logic [15:0] r;
    r = {1'b0, v[15:1]};
    if (v[0]) r = r ^ LFSR_TAPS;
    return r;
  endfunction

endpackage

// ----- hw/rtl/cache_lookup_random_replace.sv -----
// Top level: fully associative cache lookup with random replacement.
//
// Input channel (in_valid/in_ready) carries one word address per beat; the
// output channel (out_valid/out_ready) returns one result beat per address:
// hit, filled_empty, line_index, set_label and block_number.
// One shared restoring divider, one quotient bit per cycle, does all the
// arithmetic: address / words_per_block, then block number mod set_count
// while the line memory is walked one line a cycle, and on a full cache
// lfsr mod lines_in_use. in_ready is high only between items.
// The result sits in an output register; a new address is taken while it
// waits, and that item holds before its write until the receiver takes the
// earlier beat. Reset empties every line at once, restores the register
// defaults and loads the LFSR with the default seed. Configuration writes
// (cfg_we, cfg_index, cfg_data) take effect at once; a seed write also
// reloads the LFSR.
`include "cache_lookup_random_replace_macros.svh"

module cache_lookup_random_replace #(
  parameter int MAX_LINES = 16,
  parameter int ADDR_BITS = 16
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [15:0]                      word_address,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic                             hit,
  output logic                             filled_empty,
  output logic [3:0]                       line_index,
  output logic [3:0]                       set_label,
  output logic [15:0]                      block_number,
  input  logic                             cfg_we,
  input  logic [clrr_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [clrr_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam int AW  = (ADDR_BITS < 16) ? ADDR_BITS : 16;
  localparam int LW  = $clog2(MAX_LINES);
  localparam int NW  = clrr_pkg::DVR_W;

  typedef enum logic [2:0] {S_IDLE, S_DIV, S_SCAN, S_RMOD, S_WRITE} state_t;

  state_t                  state;
  logic [6:0]              wpb;
  logic [4:0]              lines;
  logic [4:0]              sets;
  logic [15:0]             lfsr;
  logic [NW-1:0]           wpb_eff;
  logic [NW-1:0]           n_eff;
  logic [NW-1:0]           sc_eff;

  clrr_pkg::div_req_t      div_req;
  clrr_pkg::div_rsp_t      div_rsp;
  logic                    div_idle;

  logic [15:0]             blk;
  logic [NW-1:0]           scan_idx;
  logic                    cmp_pend;
  logic [LW-1:0]           cmp_idx;
  logic                    hit_found;
  logic                    empty_found;
  logic [LW-1:0]           hit_line;
  logic [LW-1:0]           empty_line;
  logic [LW-1:0]           line;
  logic [3:0]              set_lbl;
  logic [MAX_LINES-1:0]    line_valid;
  logic [15:0]             line_block [MAX_LINES];
  logic [15:0]             rd_data;
  logic                    out_free;
  logic                    mem_we;

  clrr_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  assign div_idle = !div_rsp.busy && !div_req.start;
  assign out_free = !out_valid || out_ready;
  assign mem_we   = (state == S_WRITE) && out_free && !hit_found;
  assign in_ready = (state == S_IDLE);

  always_comb begin
    wpb_eff = (wpb == 7'd0) ? NW'(1) : NW'(wpb);
    if (lines == 5'd0) begin
      n_eff = NW'(1);
    end else if (NW'(lines) > NW'(MAX_LINES)) begin
      n_eff = NW'(MAX_LINES);
    end else begin
      n_eff = NW'(lines);
    end
    if (sets == 5'd0) begin
      sc_eff = NW'(1);
    end else if (sets > clrr_pkg::SETS_MAX) begin
      sc_eff = NW'(clrr_pkg::SETS_MAX);
    end else begin
      sc_eff = NW'(sets);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wpb   <= clrr_pkg::WPB_RESET;
      lines <= clrr_pkg::LINES_RESET;
      sets  <= clrr_pkg::SETS_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        clrr_pkg::CFG_WORDS_PER_BLOCK: wpb   <= cfg_data[6:0];
        clrr_pkg::CFG_LINES_IN_USE:    lines <= cfg_data[4:0];
        clrr_pkg::CFG_SET_COUNT:       sets  <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  // line memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) line_block[line] <= blk;
    rd_data <= line_block[scan_idx[LW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      out_valid     <= 1'b0;
      line_valid    <= '0;
      lfsr          <= clrr_pkg::SEED_DEFAULT;
      div_req.start <= 1'b0;
      cmp_pend      <= 1'b0;
    end else begin
      div_req.start <= 1'b0;
      if (out_valid && out_ready) out_valid <= 1'b0;
      if (cfg_we && (cfg_index == clrr_pkg::CFG_RANDOM_SEED)) begin
        lfsr <= clrr_pkg::seed_value(cfg_data);
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            div_req.start    <= 1'b1;
            div_req.dividend <= 16'(word_address[AW-1:0]);
            div_req.divisor  <= wpb_eff;
            state            <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_idle) begin
            blk              <= div_rsp.quotient;
            div_req.start    <= 1'b1;
            div_req.dividend <= div_rsp.quotient;
            div_req.divisor  <= sc_eff;
            scan_idx         <= '0;
            cmp_pend         <= 1'b0;
            hit_found        <= 1'b0;
            empty_found      <= 1'b0;
            state            <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (scan_idx < n_eff) begin
            cmp_pend <= 1'b1;
            cmp_idx  <= scan_idx[LW-1:0];
            scan_idx <= NW'(scan_idx + NW'(1));
          end else begin
            cmp_pend <= 1'b0;
          end
          // first valid match wins; otherwise remember the lowest empty line
          if (cmp_pend) begin
            if (line_valid[cmp_idx]) begin
              if (!hit_found && (rd_data == blk)) begin
                hit_found <= 1'b1;
                hit_line  <= cmp_idx;
              end
            end else if (!empty_found) begin
              empty_found <= 1'b1;
              empty_line  <= cmp_idx;
            end
          end
          if ((scan_idx >= n_eff) && !cmp_pend && div_idle) begin
            set_lbl <= div_rsp.remainder[3:0];
            if (hit_found) begin
              line  <= hit_line;
              state <= S_WRITE;
            end else if (empty_found) begin
              line  <= empty_line;
              state <= S_WRITE;
            end else begin
              div_req.start    <= 1'b1;
              div_req.dividend <= lfsr;
              div_req.divisor  <= n_eff;
              state            <= S_RMOD;
            end
          end
        end
        S_RMOD: begin
          if (div_idle) begin
            line  <= div_rsp.remainder[LW-1:0];
            lfsr  <= clrr_pkg::lfsr_next(lfsr);
            state <= S_WRITE;
          end
        end
        S_WRITE: begin
          // hold until the previous result beat has been taken
          if (out_free) begin
            line_valid[line] <= 1'b1;
            out_valid        <= 1'b1;
            hit              <= hit_found;
            filled_empty     <= !hit_found && empty_found;
            line_index       <= 4'(line);
            set_label        <= set_lbl;
            block_number     <= blk;
            state            <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `CLRR_ASSERT_IMPL(a_hit_fill_excl, out_valid, !(hit && filled_empty), "hit and fill both set")
  `CLRR_ASSERT_IMPL(a_div_done_write, state == S_WRITE, !div_rsp.busy, "divider busy at write")
  `CLRR_ASSERT_IMPL(a_line_range, state == S_WRITE, NW'(line) < n_eff, "line out of range")
  `CLRR_ASSERT_NEXT(a_lfsr_live, 1'b1, lfsr != 16'd0, "replacement LFSR locked at zero")

endmodule

// ----- hw/rtl/clrr_div.sv -----
// Shared restoring divider: one quotient bit per cycle.
module clrr_div (
  input  logic              clk,
  input  logic              rst,
  input  clrr_pkg::div_req_t req,
  output clrr_pkg::div_rsp_t rsp
);

  logic                          busy;
  logic [clrr_pkg::CNT_W-1:0]    count;
  logic [clrr_pkg::DVD_W-1:0]    shreg;
  logic [clrr_pkg::DVR_W-1:0]    rem;
  logic [clrr_pkg::DVR_W-1:0]    divisor;
  logic [clrr_pkg::DVR_W:0]      trial;
  logic                          fits;

  assign trial = {rem, shreg[clrr_pkg::DVD_W-1]};
  assign fits  = (trial >= {1'b0, divisor});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      count <= '0;
    end else if (req.start) begin
      busy    <= 1'b1;
      count   <= clrr_pkg::CNT_W'(clrr_pkg::DVD_W);
      shreg   <= req.dividend;
      rem     <= '0;
      divisor <= req.divisor;
    end else if (busy) begin
      // shift quotient bit in from the right as the dividend moves out
      shreg <= {shreg[clrr_pkg::DVD_W-2:0], fits};
      if (fits) begin
        rem <= clrr_pkg::DVR_W'(trial - {1'b0, divisor});
      end else begin
        rem <= trial[clrr_pkg::DVR_W-1:0];
      end
      count <= count - clrr_pkg::CNT_W'(1);
      busy  <= (count != clrr_pkg::CNT_W'(1));
    end
  end

  assign rsp.busy      = busy;
  assign rsp.quotient  = shreg;
  assign rsp.remainder = rem;

endmodule

// ----- tb/cache_lookup_random_replace_monitor.sv -----
// Lookup monitor: mirrors the cache state, predicts each result beat and compares it.
`timescale 1ns / 100ps

module cache_lookup_random_replace_monitor #(
  parameter int LINES = 16
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  input  logic                             in_ready,
  input  logic [15:0]                      word_address,
  input  logic                             out_valid,
  input  logic                             out_ready,
  input  logic                             hit,
  input  logic                             filled_empty,
  input  logic [3:0]                       line_index,
  input  logic [3:0]                       set_label,
  input  logic [15:0]                      block_number,
  input  logic                             cfg_we,
  input  logic [clrr_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [clrr_pkg::CFG_DATA_W-1:0]  cfg_data,
  output int                               fail_count,
  output int                               results_pending,
  output int                               lookup_count,
  output int                               hit_count,
  output int                               empty_fill_count,
  output int                               replace_count
);
  import clrr_pkg::*;

  typedef struct packed {
    logic        hit;
    logic        filled_empty;
    logic [3:0]  line_index;
    logic [3:0]  set_label;
    logic [15:0] block_number;
  } lookup_t;

  logic [6:0]  blk_words;
  logic [4:0]  active_lines;
  logic [4:0]  label_sets;
  logic [15:0] victim_lfsr;
  logic        slot_live [LINES];
  logic [15:0] slot_block [LINES];

  lookup_t expected_lookups [$];

  function automatic string describe(input lookup_t v);
    return $sformatf("hit=%b fill=%b line=%0d set=%0d block=%h",
                     v.hit, v.filled_empty, v.line_index, v.set_label, v.block_number);
  endfunction

  task automatic report_failure(input string msg);
    fail_count++;
    if (fail_count <= 10) $display("mismatch: %s", msg);
  endtask

  // Search every line in use, fill the lowest empty one, else evict by LFSR.
  function automatic lookup_t predict_lookup(input logic [15:0] addr);
    lookup_t r;
    int divisor, span, label_mod, vacant, slot, i;
    logic [15:0] blk;
    logic found;
    divisor = (blk_words == 0) ? 1 : int'(blk_words);
    span = (active_lines == 0) ? 1 : ((active_lines > LINES) ? LINES : int'(active_lines));
    label_mod = (label_sets == 0) ? 1 :
                ((label_sets > SETS_MAX) ? int'(SETS_MAX) : int'(label_sets));
    blk = 16'(int'(addr) / divisor);
    found = 1'b0;
    slot = 0;
    vacant = -1;
    for (i = 0; i < span; i++) begin
      if (slot_live[i]) begin
        if (!found && slot_block[i] == blk) begin
          found = 1'b1;
          slot = i;
        end
      end else if (vacant < 0) begin
        vacant = i;
      end
    end
    if (found) begin
      hit_count++;
    end else begin
      if (vacant >= 0) begin
        slot = vacant;
        empty_fill_count++;
      end else begin
        slot = int'(victim_lfsr) % span;
        victim_lfsr = {1'b0, victim_lfsr[15:1]} ^ (victim_lfsr[0] ? LFSR_TAPS : 16'h0000);
        replace_count++;
      end
      slot_live[slot] = 1'b1;
      slot_block[slot] = blk;
    end
    r.hit = found;
    r.filled_empty = !found && (vacant >= 0);
    r.line_index = slot[3:0];
    r.set_label = 4'(int'(blk) % label_mod);
    r.block_number = blk;
    return r;
  endfunction

  always @(posedge clk) begin
    lookup_t got, want;
    if (rst) begin
      blk_words = WPB_RESET;
      active_lines = LINES_RESET;
      label_sets = SETS_RESET;
      victim_lfsr = SEED_DEFAULT;
      slot_live = '{default: 1'b0};
      expected_lookups.delete();
      fail_count = 0;
      lookup_count = 0;
      hit_count = 0;
      empty_fill_count = 0;
      replace_count = 0;
    end else begin
      // check before predicting: a beat never answers an address taken on the same edge
      if (out_valid && out_ready) begin
        got = {hit, filled_empty, line_index, set_label, block_number};
        if (expected_lookups.size() == 0) begin
          report_failure($sformatf("result beat with no lookup outstanding: %s",
                                   describe(got)));
        end else begin
          want = expected_lookups.pop_front();
          if (got !== want)
            report_failure($sformatf("lookup %0d expected %s, got %s",
                                     lookup_count, describe(want), describe(got)));
          lookup_count++;
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_WORDS_PER_BLOCK: blk_words = cfg_data[6:0];
          CFG_LINES_IN_USE:    active_lines = cfg_data[4:0];
          CFG_SET_COUNT:       label_sets = cfg_data[4:0];
          CFG_RANDOM_SEED:     victim_lfsr = (cfg_data == 16'h0000) ? SEED_DEFAULT : cfg_data;
          default: ;
        endcase
      end
      if (in_valid && in_ready) expected_lookups.push_back(predict_lookup(word_address));
    end
    results_pending = expected_lookups.size();
  end

endmodule

// ----- tb/cache_lookup_random_replace_tb.sv -----
// Testbench top: drives lookups and register writes into the cache block, gives the verdict.
`timescale 1ns / 100ps

module cache_lookup_random_replace_tb;
  import clrr_pkg::*;

  localparam int LINES        = 16;
  localparam int CYCLE_LIMIT  = 600000;
  localparam int PHASES       = 12;
  localparam int PHASE_ITEMS  = 75;
  localparam int HOT_MAX      = 24;
  localparam int DRAIN_CYCLES = 60;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [15:0]           word_address = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic                  hit;
  logic                  filled_empty;
  logic [3:0]            line_index;
  logic [3:0]            set_label;
  logic [15:0]           block_number;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  int fail_count, results_pending, lookup_count;
  int hit_count, empty_fill_count, replace_count;
  int cycle_count = 0;

  logic        steady = 1'b0;
  int          cur_words = 4;
  int          cur_lines = 16;
  logic [15:0] hot_addr [HOT_MAX];
  int          hot_size;

  cache_lookup_random_replace #(
    .MAX_LINES(LINES),
    .ADDR_BITS(16)
  ) dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .word_address(word_address),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .hit(hit),
    .filled_empty(filled_empty),
    .line_index(line_index),
    .set_label(set_label),
    .block_number(block_number),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  cache_lookup_random_replace_monitor #(
    .LINES(LINES)
  ) u_monitor (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .word_address(word_address),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .hit(hit),
    .filled_empty(filled_empty),
    .line_index(line_index),
    .set_label(set_label),
    .block_number(block_number),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .fail_count(fail_count),
    .results_pending(results_pending),
    .lookup_count(lookup_count),
    .hit_count(hit_count),
    .empty_fill_count(empty_fill_count),
    .replace_count(replace_count)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    out_ready <= steady || ($urandom_range(0, 99) >= 30);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  task automatic send_address(input logic [15:0] addr);
    int gap;
    gap = (!steady && $urandom_range(0, 99) < 30) ? $urandom_range(1, 40) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    word_address <= addr;
    do @(posedge clk); while (!in_ready);
  endtask

  // Hold off the sender until every outstanding lookup has come back.
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(negedge clk); while (results_pending != 0);
    @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
  endtask

  task automatic program_cache(input int words, input int lines, input int sets,
                               input logic [15:0] seed);
    logic [15:0] junk;
    junk = 16'($urandom);
    // upper bits past each register's width are don't-care
    write_reg(CFG_WORDS_PER_BLOCK, {junk[15:7], 7'(words)});
    write_reg(CFG_LINES_IN_USE, {junk[10:0], 5'(lines)});
    write_reg(CFG_SET_COUNT, {junk[15:5], 5'(sets)});
    write_reg(CFG_RANDOM_SEED, seed);
    // an index past the last register must change nothing
    write_reg(CFG_RANDOM_SEED + 3'($urandom_range(1, 4)), 16'($urandom));
    cfg_we <= 1'b0;
    cur_words = (words == 0) ? 1 : words;
    cur_lines = (lines == 0) ? 1 : ((lines > LINES) ? LINES : lines);
  endtask

  initial begin
    int addr, pick, phase, n, k;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    for (k = 0; k < HOT_MAX; k++) hot_addr[k] = 16'($urandom);

    // defaults: same block twice at both ends, fill every line, then force evictions
    send_address(16'h0000);
    send_address(16'h0003);
    send_address(16'hFFFF);
    send_address(16'hFFFC);
    for (k = 1; k <= 14; k++) send_address(16'(k * 16'h1000));
    send_address(16'h0F00);
    send_address(16'h0E00);
    send_address(16'h0000);
    send_address(16'h0F03);

    for (phase = 0; phase < PHASES; phase++) begin
      wait_drained();
      repeat (4) @(posedge clk);
      case (phase)
        0: program_cache(1, 16, 16, 16'h0001);
        1: program_cache(64, 1, 1, 16'hFFFF);
        2: program_cache(0, 0, 0, 16'h0000);
        3: program_cache(127, 31, 31, 16'hA5A5);
        4: program_cache(2, 3, 5, 16'($urandom));
        // shrink then regrow so lines left outside keep their blocks
        5: program_cache(4, 2, 7, 16'($urandom));
        default: program_cache($urandom_range(0, 3) == 0 ? $urandom_range(0, 127)
                                                         : $urandom_range(1, 8),
                               $urandom_range(0, 31), $urandom_range(0, 31),
                               16'($urandom));
      endcase
      for (k = 0; k < HOT_MAX; k++)
        if ($urandom_range(0, 1) == 0) hot_addr[k] = 16'($urandom);
      hot_size = cur_lines + $urandom_range(1, 8);
      if (hot_size > HOT_MAX) hot_size = HOT_MAX;
      if (phase == 6) steady <= 1'b1;
      for (n = 0; n < PHASE_ITEMS; n++) begin
        if (phase == 7 && n == PHASE_ITEMS / 2) wait_drained();
        if ($urandom_range(0, 99) < 70) begin
          pick = $urandom_range(0, hot_size - 1);
          addr = int'(hot_addr[pick]) + $urandom_range(0, cur_words - 1);
          if (addr > 16'hFFFF) addr = hot_addr[pick];
        end else begin
          addr = $urandom_range(0, 16'hFFFF);
        end
        send_address(16'(addr));
      end
      if (phase == 6) steady <= 1'b0;
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
    $display("checked %0d lookups across %0d register settings, unused indexes included",
             lookup_count, PHASES + 1);
    $display("%0d hits, %0d fills of empty lines, %0d LFSR evictions",
             hit_count, empty_fill_count, replace_count);
    if (fail_count == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+hw/rtl
hw/rtl/clrr_pkg.sv
hw/rtl/clrr_div.sv
hw/rtl/cache_lookup_random_replace.sv
tb/cache_lookup_random_replace_monitor.sv
tb/cache_lookup_random_replace_tb.sv
